/* sv/irn_pkg.sv */
package irn_pkg;

  // Field widths
  localparam int NUM_W = 14;   // input number as it arrives
  localparam int VAL_W = 13;   // working value, 1..5000 fits
  localparam int SYM_W = 7;    // ASCII symbol
  localparam int DIG_W = 4;    // one decimal digit
  localparam int LEN_W = 3;    // characters in one place, at most five
  localparam int UA_W  = 4;    // microcode address

  localparam logic [NUM_W-1:0] UPPER_LIMIT = NUM_W'(5000);

  // ASCII codes of the numeral letters
  localparam logic [SYM_W-1:0] SYM_NONE = 7'h00;
  localparam logic [SYM_W-1:0] SYM_I    = 7'h49;
  localparam logic [SYM_W-1:0] SYM_V    = 7'h56;
  localparam logic [SYM_W-1:0] SYM_X    = 7'h58;
  localparam logic [SYM_W-1:0] SYM_L    = 7'h4c;
  localparam logic [SYM_W-1:0] SYM_C    = 7'h43;
  localparam logic [SYM_W-1:0] SYM_D    = 7'h44;
  localparam logic [SYM_W-1:0] SYM_M    = 7'h4d;

  // Decimal places
  localparam logic [1:0] PL_UNITS     = 2'd0;
  localparam logic [1:0] PL_TENS      = 2'd1;
  localparam logic [1:0] PL_HUNDREDS  = 2'd2;
  localparam logic [1:0] PL_THOUSANDS = 2'd3;

  // Pattern columns: one, five and ten of a place
  localparam logic [1:0] COL_ONE  = 2'd0;
  localparam logic [1:0] COL_FIVE = 2'd1;
  localparam logic [1:0] COL_TEN  = 2'd2;

  // Micro-operations
  typedef enum logic [1:0] {
    OP_IDLE  = 2'd0,   // wait for a word, branch on range check
    OP_SPLIT = 2'd1,   // peel one decimal digit off the working value
    OP_EMIT  = 2'd2,   // send the characters of one place
    OP_BAD   = 2'd3    // send the single invalid word
  } uop_t;

  typedef struct packed {
    uop_t            op;
    logic [1:0]      place;
    logic [UA_W-1:0] nxt;
    logic [UA_W-1:0] jmp;
  } uword_t;

  // Microcode addresses
  localparam logic [UA_W-1:0] UA_IDLE     = 4'd0;
  localparam logic [UA_W-1:0] UA_SPLIT_TH = 4'd1;
  localparam logic [UA_W-1:0] UA_SPLIT_HU = 4'd2;
  localparam logic [UA_W-1:0] UA_SPLIT_TE = 4'd3;
  localparam logic [UA_W-1:0] UA_EMIT_TH  = 4'd4;
  localparam logic [UA_W-1:0] UA_EMIT_HU  = 4'd5;
  localparam logic [UA_W-1:0] UA_EMIT_TE  = 4'd6;
  localparam logic [UA_W-1:0] UA_EMIT_UN  = 4'd7;
  localparam logic [UA_W-1:0] UA_BAD      = 4'd8;

  function automatic uword_t uw_make(uop_t op, logic [1:0] place,
                                     logic [UA_W-1:0] nxt, logic [UA_W-1:0] jmp);
    uword_t w;
    w.op    = op;
    w.place = place;
    w.nxt   = nxt;
    w.jmp   = jmp;
    return w;
  endfunction

  // Control store: split all digits first so the last flag is known, then emit
  function automatic uword_t ucode(logic [UA_W-1:0] addr);
    uword_t w;
    case (addr)
      UA_IDLE:     w = uw_make(OP_IDLE,  PL_UNITS,     UA_SPLIT_TH, UA_BAD);
      UA_SPLIT_TH: w = uw_make(OP_SPLIT, PL_THOUSANDS, UA_SPLIT_HU, UA_IDLE);
      UA_SPLIT_HU: w = uw_make(OP_SPLIT, PL_HUNDREDS,  UA_SPLIT_TE, UA_IDLE);
      UA_SPLIT_TE: w = uw_make(OP_SPLIT, PL_TENS,      UA_EMIT_TH,  UA_IDLE);
      UA_EMIT_TH:  w = uw_make(OP_EMIT,  PL_THOUSANDS, UA_EMIT_HU,  UA_IDLE);
      UA_EMIT_HU:  w = uw_make(OP_EMIT,  PL_HUNDREDS,  UA_EMIT_TE,  UA_IDLE);
      UA_EMIT_TE:  w = uw_make(OP_EMIT,  PL_TENS,      UA_EMIT_UN,  UA_IDLE);
      UA_EMIT_UN:  w = uw_make(OP_EMIT,  PL_UNITS,     UA_IDLE,     UA_IDLE);
      UA_BAD:      w = uw_make(OP_BAD,   PL_UNITS,     UA_IDLE,     UA_IDLE);
      default:     w = uw_make(OP_IDLE,  PL_UNITS,     UA_IDLE,     UA_IDLE);
    endcase
    return w;
  endfunction

  // Weight of one unit of a place
  function automatic logic [NUM_W-1:0] place_base(logic [1:0] place);
    logic [NUM_W-1:0] b;
    case (place)
      PL_THOUSANDS: b = NUM_W'(1000);
      PL_HUNDREDS:  b = NUM_W'(100);
      PL_TENS:      b = NUM_W'(10);
      default:      b = NUM_W'(1);
    endcase
    return b;
  endfunction

  // Characters in the pattern of a digit below the thousands
  function automatic logic [LEN_W-1:0] pat_len(logic [DIG_W-1:0] d);
    logic [LEN_W-1:0] n;
    case (d)
      4'd1, 4'd5:       n = 3'd1;
      4'd2, 4'd4, 4'd6,
      4'd9:             n = 3'd2;
      4'd3, 4'd7:       n = 3'd3;
      4'd8:             n = 3'd4;
      default:          n = 3'd0;
    endcase
    return n;
  endfunction

  // Column of character k in the pattern of digit d
  function automatic logic [1:0] pat_col(logic [DIG_W-1:0] d, logic [LEN_W-1:0] k);
    logic [1:0] c;
    case (d)
      4'd4:             c = (k == 3'd0) ? COL_ONE  : COL_FIVE;
      4'd5:             c = COL_FIVE;
      4'd6, 4'd7, 4'd8: c = (k == 3'd0) ? COL_FIVE : COL_ONE;
      4'd9:             c = (k == 3'd0) ? COL_ONE  : COL_TEN;
      default:          c = COL_ONE;
    endcase
    return c;
  endfunction

  // Letter for a column of a place
  function automatic logic [SYM_W-1:0] sym_of(logic [1:0] place, logic [1:0] col);
    logic [SYM_W-1:0] s;
    case (place)
      PL_UNITS:    s = (col == COL_ONE) ? SYM_I : (col == COL_FIVE) ? SYM_V : SYM_X;
      PL_TENS:     s = (col == COL_ONE) ? SYM_X : (col == COL_FIVE) ? SYM_L : SYM_C;
      PL_HUNDREDS: s = (col == COL_ONE) ? SYM_C : (col == COL_FIVE) ? SYM_D : SYM_M;
      default:     s = SYM_M;
    endcase
    return s;
  endfunction

endpackage

/* sv/irn_split.sv */
module irn_split (
  input  logic [irn_pkg::VAL_W-1:0] value,
  input  logic [1:0]                place,
  output logic [irn_pkg::DIG_W-1:0] digit,
  output logic [irn_pkg::VAL_W-1:0] remainder
);
  import irn_pkg::*;

  logic [NUM_W-1:0] base;
  logic [NUM_W-1:0] mult;
  logic [NUM_W-1:0] val_ext;

  assign base    = place_base(place);
  assign val_ext = NUM_W'(value);

  // Compare against each multiple of the place weight, keep the largest that fits
  always_comb begin
    digit     = '0;
    remainder = value;
    mult      = '0;
    for (int k = 1; k <= 9; k++) begin
      mult = NUM_W'(base * NUM_W'(k));
      if (val_ext >= mult) begin
        digit     = DIG_W'(k);
        remainder = VAL_W'(val_ext - mult);
      end
    end
  end

endmodule

/* sv/integer_to_roman_numeral_core.sv */
// Integer to Roman numeral converter. Each input word carries a 14-bit number; a number
// from 1 to 5000 comes out as its Roman numeral, one ASCII letter per output word, most
// significant first, with up to five M for the thousands and out_last set on the final
// letter. A number of 0 or above 5000 gives one word with out_invalid and out_last set
// and a zero symbol. A small microcoded sequencer runs the work: an idle step takes the
// word, three split steps peel off the thousands, hundreds and tens digits through a
// compare-and-subtract unit, then emit steps send the letters of each of the four places,
// one letter per cycle while the output is not stalled; the emit step of a place whose
// digit is zero sends nothing and passes on. An invalid number gets one word from its step.
// in_ready is high only while the sequencer waits at its idle step; the letter register
// on the output lets the last word of one run sit there while the next number is taken.
module integer_to_roman_numeral_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [irn_pkg::NUM_W-1:0] in_number,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [irn_pkg::SYM_W-1:0] out_symbol,
  output logic                      out_invalid,
  output logic                      out_last
);
  import irn_pkg::*;

  logic [UA_W-1:0]  pc_r, pc_nxt;
  logic [LEN_W-1:0] k_r, k_nxt;
  logic [VAL_W-1:0] rem_r, rem_nxt;
  logic [DIG_W-1:0] d_r [4];
  logic [DIG_W-1:0] d_nxt [4];
  logic             out_valid_r, out_valid_nxt;
  logic [SYM_W-1:0] out_symbol_r, out_symbol_nxt;
  logic             out_invalid_r, out_invalid_nxt;
  logic             out_last_r, out_last_nxt;

  uword_t           uw;
  logic             bad;
  logic             can_emit;
  logic [DIG_W-1:0] cur_d;
  logic [LEN_W-1:0] len;
  logic [1:0]       col;
  logic             last_ch;
  logic             low_zero;
  logic [DIG_W-1:0] sp_digit;
  logic [VAL_W-1:0] sp_rem;

  // Fetch the control word of the current step
  assign uw       = ucode(pc_r);
  assign in_ready = (uw.op == OP_IDLE);
  assign bad      = (in_number == '0) || (in_number > UPPER_LIMIT);
  assign can_emit = !out_valid_r || out_ready;

  irn_split u_split (
    .value     (rem_r),
    .place     (uw.place),
    .digit     (sp_digit),
    .remainder (sp_rem)
  );

  // Pattern of the place being sent
  assign cur_d   = d_r[uw.place];
  assign len     = (uw.place == PL_THOUSANDS) ? cur_d[LEN_W-1:0] : pat_len(cur_d);
  assign col     = (uw.place == PL_THOUSANDS) ? COL_ONE : pat_col(cur_d, k_r);
  assign last_ch = (k_r == len - LEN_W'(1));

  // Check that no lower place has letters to follow
  always_comb begin
    low_zero = 1'b1;
    for (int i = 0; i < 4; i++) begin
      if ((2'(i) < uw.place) && (d_r[2'(i)] != '0)) low_zero = 1'b0;
    end
  end

  // Execute the control word
  always_comb begin
    pc_nxt          = pc_r;
    k_nxt           = k_r;
    rem_nxt         = rem_r;
    d_nxt           = d_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_symbol_nxt  = out_symbol_r;
    out_invalid_nxt = out_invalid_r;
    out_last_nxt    = out_last_r;
    case (uw.op)
      OP_IDLE: begin
        if (in_valid) begin
          rem_nxt = in_number[VAL_W-1:0];
          pc_nxt  = bad ? uw.jmp : uw.nxt;
        end
      end
      OP_SPLIT: begin
        d_nxt[uw.place] = sp_digit;
        rem_nxt         = sp_rem;
        if (uw.place == PL_TENS) d_nxt[PL_UNITS] = sp_rem[DIG_W-1:0];
        k_nxt  = '0;
        pc_nxt = uw.nxt;
      end
      OP_EMIT: begin
        if (len == '0) begin
          pc_nxt = uw.nxt;
        end else if (can_emit) begin
          out_valid_nxt   = 1'b1;
          out_symbol_nxt  = sym_of(uw.place, col);
          out_invalid_nxt = 1'b0;
          out_last_nxt    = last_ch && low_zero;
          if (last_ch) begin
            k_nxt  = '0;
            pc_nxt = uw.nxt;
          end else begin
            k_nxt = k_r + LEN_W'(1);
          end
        end
      end
      OP_BAD: begin
        if (can_emit) begin
          out_valid_nxt   = 1'b1;
          out_symbol_nxt  = SYM_NONE;
          out_invalid_nxt = 1'b1;
          out_last_nxt    = 1'b1;
          pc_nxt          = uw.nxt;
        end
      end
      default: pc_nxt = UA_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= UA_IDLE;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    rem_r         <= rem_nxt;
    d_r           <= d_nxt;
    out_symbol_r  <= out_symbol_nxt;
    out_invalid_r <= out_invalid_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_symbol  = out_symbol_r;
  assign out_invalid = out_invalid_r;
  assign out_last    = out_last_r;

endmodule

/* sv/irn_checker.sv */
module irn_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [irn_pkg::SYM_W-1:0] out_symbol,
  input logic                      out_invalid,
  input logic                      out_last
);
  import irn_pkg::*;

  // Hold a stalled output word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_symbol)
      && $stable(out_invalid) && $stable(out_last))
    else $error("output word changed while stalled");

  // An invalid word is a lone zero symbol ending its run
  a_bad_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_invalid |-> out_last && (out_symbol == SYM_NONE))
    else $error("invalid word malformed");

  // A valid word carries one of the numeral letters
  a_letter: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_invalid |-> (out_symbol == SYM_I) || (out_symbol == SYM_V)
      || (out_symbol == SYM_X) || (out_symbol == SYM_L) || (out_symbol == SYM_C)
      || (out_symbol == SYM_D) || (out_symbol == SYM_M))
    else $error("unexpected symbol");

  // One number at a time: no second word straight after an accept
  a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

endmodule

bind integer_to_roman_numeral_core irn_checker u_irn_checker (.*);
